FILE: rtl/core/ffa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_pkg
// Types, constants and state codes shared by the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

    localparam int HEAP_GRANULES   = 4096;
    // The page size must be a power of two; page rounding is done by masking.
    localparam int PAGE_GRANULES   = 512;
    localparam int HEADER_GRANULES = 4;
    localparam int INITIAL_PAGES   = 1;

    localparam int INIT_END = (INITIAL_PAGES * PAGE_GRANULES > HEAP_GRANULES) ?
                              HEAP_GRANULES : INITIAL_PAGES * PAGE_GRANULES;
    localparam int INIT_SIZE = (INIT_END >= HEADER_GRANULES) ?
                               INIT_END - HEADER_GRANULES : 0;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OOM  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    typedef struct packed {
        logic        command;
        logic [11:0] alloc_size;
        logic [11:0] block_address;
    } req_t;

    typedef struct packed {
        logic [11:0] result_address;
        logic [1:0]  status;
    } rsp_t;

    // One chunk header as held in the header memory.
    typedef struct packed {
        logic        valid;
        logic        free;
        logic [12:0] size;
        logic [11:0] prev;
    } hdr_t;

    typedef struct packed {
        logic        we;
        logic [11:0] waddr;
        hdr_t        wdata;
        logic        re;
        logic [11:0] raddr;
    } mem_req_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_A_CHK,
        S_GROW,
        S_G_CHK,
        S_TAKE,
        S_T_WC,
        S_F_CHK,
        S_F_R,
        S_F_WC,
        S_F_P,
        S_F_PW,
        S_F_LR,
        S_F_L,
        S_P_RD,
        S_P_WR,
        S_DONE
    } state_t;

endpackage

FILE: rtl/core/first_fit_heap_allocator.sv
`timescale 1ns / 1ps
// An allocate of size zero is answered without touching the header memory; any other
// allocate walks the chunk headers and may then grow the heap, split a chunk or relink.
// A free checks the chunk and may merge it with its neighbors and trim the heap end.
// Requests are taken one word at a time, only in the idle state. Reset: a clearing pass
// writes all 4096 header entries before the first request word is taken.
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap allocator with splitting, page growth and coalescing.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  ffa_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output ffa_pkg::rsp_t rsp
);
    import ffa_pkg::*;

    mem_req_t mem_req;
    hdr_t     rdata;

    ffa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .mem_req   (mem_req),
        .rdata     (rdata)
    );

    ffa_hdr_mem u_mem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (rdata)
    );

`ifndef SYNTH
    // A read never races a write to the same header entry.
    a_no_rw_same: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_req.we && mem_req.re && mem_req.waddr == mem_req.raddr))
        else $error("header read and write collide");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status != ST_OK) |-> (rsp.result_address == '0))
        else $error("failed word carries an address");

    a_addr_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.result_address != '0) |->
            (rsp.result_address >= 12'(HEADER_GRANULES)))
        else $error("result address inside header");
`endif

endmodule

FILE: rtl/core/ffa_hdr_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_hdr_mem
// Chunk header memory: one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module ffa_hdr_mem (
    input  logic              clk,
    input  ffa_pkg::mem_req_t req,
    output ffa_pkg::hdr_t     rdata
);
    import ffa_pkg::*;

    hdr_t mem [HEAP_GRANULES];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata <= mem[req.raddr];
        end
    end

endmodule

FILE: rtl/core/ffa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_ctrl
// Sequencer that walks, splits, grows, merges and releases chunk headers.
// ----------------------------------------------------------------------------
module ffa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  ffa_pkg::req_t     req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output ffa_pkg::rsp_t     rsp,
    output ffa_pkg::mem_req_t mem_req,
    input  ffa_pkg::hdr_t     rdata
);
    import ffa_pkg::*;

    localparam logic [13:0] HDR14  = 14'(HEADER_GRANULES);
    localparam logic [13:0] HEAP14 = 14'(HEAP_GRANULES);
    localparam logic [13:0] PMASK  = 14'(PAGE_GRANULES - 1);

    state_t      state_reg, state_next;
    state_t      ret_reg, ret_next;
    logic [11:0] clr_reg, clr_next;
    logic [11:0] last_reg, last_next;
    logic [12:0] end_reg, end_next;
    logic        rsp_valid_reg, rsp_valid_next;
    rsp_t        rsp_reg, rsp_next;
    logic [11:0] res_reg, res_next;
    logic [11:0] size_reg, size_next;
    logic [11:0] c_reg, c_next;
    hdr_t        hdr_reg, hdr_next;
    logic [11:0] p_reg, p_next;
    logic [11:0] r_reg, r_next;
    logic [11:0] pa_reg, pa_next;
    logic [11:0] pv_reg, pv_next;
    logic [13:0] grow_reg, grow_next;
    logic [1:0]  st_reg, st_next;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            ret_reg       <= S_DONE;
            clr_reg       <= '0;
            last_reg      <= '0;
            end_reg       <= 13'(INIT_END);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            clr_reg       <= clr_next;
            last_reg      <= last_next;
            end_reg       <= end_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg  <= rsp_next;
        res_reg  <= res_next;
        size_reg <= size_next;
        c_reg    <= c_next;
        hdr_reg  <= hdr_next;
        p_reg    <= p_next;
        r_reg    <= r_next;
        pa_reg   <= pa_next;
        pv_reg   <= pv_next;
        grow_reg <= grow_next;
        st_reg   <= st_next;
    end

    always_comb
    begin
        logic [13:0] sz14;
        logic [13:0] c14;
        logic [13:0] hs14;
        logic [13:0] nxt14;
        logic [13:0] need14;
        logic [13:0] pg14;
        logic [13:0] end14;
        logic [12:0] nsize;
        hdr_t        h;

        state_next     = state_reg;
        ret_next       = ret_reg;
        clr_next       = clr_reg;
        last_next      = last_reg;
        end_next       = end_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        res_next       = res_reg;
        size_next      = size_reg;
        c_next         = c_reg;
        hdr_next       = hdr_reg;
        p_next         = p_reg;
        r_next         = r_reg;
        pa_next        = pa_reg;
        pv_next        = pv_reg;
        grow_next      = grow_reg;
        st_next        = st_reg;
        mem_req        = '0;

        sz14   = {2'b00, size_reg};
        c14    = {2'b00, c_reg};
        hs14   = {1'b0, hdr_reg.size};
        end14  = {1'b0, end_reg};
        need14 = sz14 + HDR14;
        pg14   = (need14 + PMASK) & ~PMASK;
        nxt14  = '0;
        nsize  = '0;
        h      = rdata;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = clr_reg;
                if (clr_reg == '0)
                begin
                    mem_req.wdata = '{valid: 1'b1, free: 1'b1,
                                      size: 13'(INIT_SIZE), prev: 12'd0};
                end
                clr_next = clr_reg + 12'd1;
                if (clr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                st_next  = ST_OK;
                res_next = '0;
                if (req_valid)
                begin
                    size_next = req.alloc_size;
                    if (req.command == CMD_ALLOC)
                    begin
                        if (req.alloc_size == '0)
                        begin
                            st_next    = ST_ZERO;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            c_next        = '0;
                            mem_req.re    = 1'b1;
                            mem_req.raddr = '0;
                            state_next    = S_A_CHK;
                        end
                    end
                    else
                    begin
                        nxt14 = {2'b00, req.block_address} - HDR14;
                        if (req.block_address < 12'(HEADER_GRANULES) || nxt14 >= end14)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            c_next        = nxt14[11:0];
                            mem_req.re    = 1'b1;
                            mem_req.raddr = nxt14[11:0];
                            state_next    = S_F_CHK;
                        end
                    end
                end
            end

            S_A_CHK:
            begin
                nxt14 = c14 + HDR14 + {1'b0, h.size};
                if (h.free && ({1'b0, h.size} == sz14 || {1'b0, h.size} > need14))
                begin
                    hdr_next   = h;
                    state_next = S_TAKE;
                end
                else if (c_reg == last_reg || nxt14 >= end14)
                begin
                    state_next = S_GROW;
                end
                else
                begin
                    c_next        = nxt14[11:0];
                    mem_req.re    = 1'b1;
                    mem_req.raddr = nxt14[11:0];
                end
            end

            S_GROW:
            begin
                grow_next = pg14;
                if (end14 > HEAP14 || pg14 > HEAP14 - end14)
                begin
                    st_next    = ST_OOM;
                    state_next = S_DONE;
                end
                else
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = last_reg;
                    state_next    = S_G_CHK;
                end
            end

            S_G_CHK:
            begin
                nxt14    = end14 + grow_reg;
                end_next = nxt14[12:0];
                if (h.free)
                begin
                    hdr_next      = h;
                    hdr_next.size = h.size + grow_reg[12:0];
                    c_next        = last_reg;
                end
                else
                begin
                    c_next        = end_reg[11:0];
                    hdr_next      = '{valid: 1'b1, free: 1'b1,
                                      size: grow_reg[12:0] - 13'(HEADER_GRANULES),
                                      prev: last_reg};
                    last_next     = end_reg[11:0];
                end
                state_next = S_TAKE;
            end

            S_TAKE:
            begin
                res_next = c_reg + 12'(HEADER_GRANULES);
                st_next  = ST_OK;
                if (hs14 > need14)
                begin
                    // Split: the tail becomes a new free chunk.
                    nxt14         = c14 + need14;
                    mem_req.we    = 1'b1;
                    mem_req.waddr = nxt14[11:0];
                    mem_req.wdata = '{valid: 1'b1, free: 1'b1,
                                      size: hdr_reg.size - need14[12:0], prev: c_reg};
                    pv_next       = nxt14[11:0];
                    nxt14         = c14 + HDR14 + hs14;
                    pa_next       = nxt14[11:0];
                    ret_next      = S_DONE;
                    hdr_next.size = {1'b0, size_reg};
                    if (c_reg == last_reg)
                    begin
                        last_next = pv_next;
                        r_next    = '0;
                    end
                    else if (nxt14 < HEAP14)
                    begin
                        r_next = 12'd1;
                    end
                    else
                    begin
                        r_next = '0;
                    end
                    state_next = S_T_WC;
                end
                else
                begin
                    mem_req.we         = 1'b1;
                    mem_req.waddr      = c_reg;
                    mem_req.wdata      = hdr_reg;
                    mem_req.wdata.free = 1'b0;
                    state_next         = S_DONE;
                end
            end

            S_T_WC:
            begin
                mem_req.we         = 1'b1;
                mem_req.waddr      = c_reg;
                mem_req.wdata      = hdr_reg;
                mem_req.wdata.free = 1'b0;
                // r_reg bit zero flags a pending back-link update.
                state_next = r_reg[0] ? S_P_RD : S_DONE;
            end

            S_F_CHK:
            begin
                if (!h.valid || h.free)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    hdr_next      = h;
                    hdr_next.free = 1'b1;
                    p_next        = h.prev;
                    nxt14         = c14 + HDR14 + {1'b0, h.size};
                    r_next        = nxt14[11:0];
                    if (c_reg != last_reg && nxt14 < HEAP14)
                    begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = nxt14[11:0];
                        state_next    = S_F_R;
                    end
                    else
                    begin
                        state_next = S_F_WC;
                    end
                end
            end

            S_F_R:
            begin
                state_next = S_F_WC;
                if (h.free)
                begin
                    nsize         = hdr_reg.size + h.size + 13'(HEADER_GRANULES);
                    hdr_next.size = nsize;
                    mem_req.we    = 1'b1;
                    mem_req.waddr = r_reg;
                    mem_req.wdata = '0;
                    if (r_reg == last_reg)
                    begin
                        last_next = c_reg;
                    end
                    else
                    begin
                        nxt14 = c14 + HDR14 + {1'b0, nsize};
                        if (nxt14 < HEAP14)
                        begin
                            pa_next    = nxt14[11:0];
                            pv_next    = c_reg;
                            ret_next   = S_F_WC;
                            state_next = S_P_RD;
                        end
                    end
                end
            end

            S_F_WC:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = c_reg;
                mem_req.wdata = hdr_reg;
                if (c_reg != '0)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = p_reg;
                    state_next    = S_F_P;
                end
                else
                begin
                    state_next = S_F_LR;
                end
            end

            S_F_P:
            begin
                if (h.free)
                begin
                    // The left neighbor absorbs this chunk.
                    hdr_next      = h;
                    hdr_next.size = h.size + hdr_reg.size + 13'(HEADER_GRANULES);
                    mem_req.we    = 1'b1;
                    mem_req.waddr = c_reg;
                    mem_req.wdata = '0;
                    state_next    = S_F_PW;
                end
                else
                begin
                    state_next = S_F_LR;
                end
            end

            S_F_PW:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = p_reg;
                mem_req.wdata = hdr_reg;
                state_next    = S_F_LR;
                if (c_reg == last_reg)
                begin
                    last_next = p_reg;
                end
                else
                begin
                    nxt14 = {2'b00, p_reg} + HDR14 + hs14;
                    if (nxt14 < HEAP14)
                    begin
                        pa_next    = nxt14[11:0];
                        pv_next    = p_reg;
                        ret_next   = S_F_LR;
                        state_next = S_P_RD;
                    end
                end
            end

            S_F_LR:
            begin
                mem_req.re    = 1'b1;
                mem_req.raddr = last_reg;
                state_next    = S_F_L;
            end

            S_F_L:
            begin
                if (h.free && last_reg != '0)
                begin
                    end_next      = {1'b0, last_reg};
                    last_next     = h.prev;
                    mem_req.we    = 1'b1;
                    mem_req.waddr = last_reg;
                    mem_req.wdata = '0;
                end
                state_next = S_DONE;
            end

            S_P_RD:
            begin
                mem_req.re    = 1'b1;
                mem_req.raddr = pa_reg;
                state_next    = S_P_WR;
            end

            S_P_WR:
            begin
                mem_req.we         = 1'b1;
                mem_req.waddr      = pa_reg;
                mem_req.wdata      = h;
                mem_req.wdata.prev = pv_reg;
                state_next         = ret_reg;
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next          = 1'b1;
                    rsp_next.status         = st_reg;
                    rsp_next.result_address = res_reg;
                    if (st_reg != ST_OK)
                    begin
                        rsp_next.result_address = '0;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: tb/sv/tb_first_fit_heap_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_heap_allocator
// Drives allocate and free words into the heap allocator and checks every
// response against a behavioral model of the chunk list kept in the bench.
// ----------------------------------------------------------------------------
module tb_first_fit_heap_allocator;
    import ffa_pkg::*;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    first_fit_heap_allocator dut (
        .clk(clk), .rst_n(rst_n), .req_valid(req_valid), .req_ready(req_ready),
        .req(req), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
    );

    // Bench copy of the chunk list.
    bit          hv [HEAP_GRANULES];
    bit          hf [HEAP_GRANULES];
    int unsigned hsz [HEAP_GRANULES];
    int unsigned hprev [HEAP_GRANULES];
    int unsigned last_start;
    int unsigned heap_top;

    req_t pending_reqs[$];
    rsp_t expected_rsps[$];
    int unsigned live_blocks[$];
    int   errors = 0;
    bit   idle_off = 0;
    bit   hold_rsp = 0;
    bit   hold_go = 0;
    bit   hold_done = 0;

    function automatic int unsigned next_of(int unsigned c);
        return c + HEADER_GRANULES + hsz[c];
    endfunction

    function automatic void join_next(int unsigned c);
        int unsigned r;
        int unsigned n;
        r = next_of(c);
        hsz[c] += hsz[r] + HEADER_GRANULES;
        hv[r] = 0;
        hf[r] = 0;
        if (r == last_start) last_start = c;
        else
        begin
            n = next_of(c);
            if (n < HEAP_GRANULES) hprev[n] = c;
        end
    endfunction

    function automatic void claim(int unsigned c, int unsigned sz);
        int unsigned s;
        int unsigned old_next;
        if (hsz[c] > sz + HEADER_GRANULES)
        begin
            s = c + HEADER_GRANULES + sz;
            old_next = next_of(c);
            hv[s] = 1;
            hf[s] = 1;
            hsz[s] = hsz[c] - sz - HEADER_GRANULES;
            hprev[s] = c;
            hsz[c] = sz;
            if (c == last_start) last_start = s;
            else if (old_next < HEAP_GRANULES) hprev[old_next] = s;
        end
        hf[c] = 0;
    endfunction

    function automatic void heap_reset();
        for (int i = 0; i < HEAP_GRANULES; i++)
        begin
            hv[i] = 0; hf[i] = 0; hsz[i] = 0; hprev[i] = 0;
        end
        heap_top = INIT_END;
        hv[0] = 1;
        hf[0] = 1;
        hsz[0] = INIT_SIZE;
        last_start = 0;
    endfunction

    function automatic void release_block(int unsigned a);
        int unsigned c;
        int unsigned p;
        int unsigned l;
        if (a < HEADER_GRANULES) return;
        c = a - HEADER_GRANULES;
        if (c >= heap_top || c >= HEAP_GRANULES || !hv[c] || hf[c]) return;
        hf[c] = 1;
        p = hprev[c];
        if (c != last_start && next_of(c) < HEAP_GRANULES && hf[next_of(c)])
            join_next(c);
        if (c != 0 && p < HEAP_GRANULES && hf[p]) join_next(p);
        if (hf[last_start] && last_start != 0)
        begin
            l = last_start;
            heap_top = l;
            last_start = hprev[l];
            hv[l] = 0;
            hf[l] = 0;
        end
    endfunction

    function automatic rsp_t allocate(int unsigned sz);
        rsp_t o;
        int unsigned c;
        int unsigned need;
        int unsigned grow;
        o.result_address = '0;
        o.status = ST_OK;
        if (sz == 0)
        begin
            o.status = ST_ZERO;
            return o;
        end
        c = 0;
        for (int i = 0; i < HEAP_GRANULES; i++)
        begin
            if (hf[c] && (hsz[c] == sz || hsz[c] > sz + HEADER_GRANULES))
            begin
                claim(c, sz);
                o.result_address = 12'(c + HEADER_GRANULES);
                return o;
            end
            if (c == last_start) break;
            c = next_of(c);
            if (c >= heap_top || c >= HEAP_GRANULES) break;
        end
        need = sz + HEADER_GRANULES;
        grow = ((need + PAGE_GRANULES - 1) / PAGE_GRANULES) * PAGE_GRANULES;
        if (heap_top > HEAP_GRANULES || grow > HEAP_GRANULES - heap_top)
        begin
            o.status = ST_OOM;
            return o;
        end
        if (hf[last_start])
        begin
            hsz[last_start] += grow;
            heap_top += grow;
            c = last_start;
        end
        else
        begin
            c = heap_top;
            heap_top += grow;
            hv[c] = 1;
            hf[c] = 1;
            hsz[c] = grow - HEADER_GRANULES;
            hprev[c] = last_start;
            last_start = c;
        end
        claim(c, sz);
        o.result_address = 12'(c + HEADER_GRANULES);
        return o;
    endfunction

    function automatic req_t make_word(logic cmd, int unsigned sz, int unsigned a);
        req_t w;
        w.command = cmd;
        w.alloc_size = 12'(sz);
        w.block_address = 12'(a);
        return w;
    endfunction

    initial clk = 0;
    always #5 clk = ~clk;

    // Feeding the allocator.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 0;
            req <= '0;
        end
        else if (!req_valid || req_ready)
        begin
            if (pending_reqs.size() > 0 && (idle_off || $urandom_range(99) >= 17))
            begin
                req <= pending_reqs.pop_front();
                req_valid <= 1;
            end
            else
                req_valid <= 0;
        end
    end

    // Prediction at acceptance, check at response.
    always @(posedge clk)
    begin
        if (rst_n && req_valid && req_ready)
        begin
            if (req.command == CMD_ALLOC)
                expected_rsps.push_back(allocate(req.alloc_size));
            else
            begin
                release_block(req.block_address);
                expected_rsps.push_back('0);
            end
        end
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_rsps.size() == 0)
            begin
                $error("response word with nothing expected");
                errors++;
            end
            else
            begin
                rsp_t e;
                e = expected_rsps.pop_front();
                if (rsp.result_address !== e.result_address)
                begin
                    $error("result_address expected %0d got %0d",
                           e.result_address, rsp.result_address);
                    errors++;
                end
                if (rsp.status !== e.status)
                begin
                    $error("status expected %0d got %0d", e.status, rsp.status);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) rsp_ready <= 0;
        else rsp_ready <= !hold_rsp && (idle_off || $urandom_range(99) >= 17);
    end

    // The receiver holds off on its own count of cycles once asked to.
    initial
    begin
        wait (hold_go);
        @(negedge clk);
        hold_rsp = 1;
        repeat (300) @(negedge clk);
        hold_rsp = 0;
        hold_done = 1;
    end

    // The bench tracks which blocks it believes are live, to free them later.
    task automatic push_alloc(int unsigned sz);
        pending_reqs.push_back(make_word(CMD_ALLOC, sz, $urandom_range(4095)));
    endtask

    task automatic push_free(int unsigned a);
        pending_reqs.push_back(make_word(CMD_FREE, $urandom_range(4095), a));
    endtask

    task automatic drain();
        @(negedge clk);
        while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
            @(negedge clk);
    endtask

    initial
    begin
        int unsigned a;
        int unsigned pick;
        heap_reset();
        rst_n = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1;

        // Directed: zero size, exact fit, extremes, out of memory, bad frees.
        push_alloc(0);
        push_alloc(INIT_SIZE);
        push_free(HEADER_GRANULES);
        push_free(HEADER_GRANULES);
        push_free(0);
        push_free(1);
        push_free(4095);
        push_alloc(4095);
        push_alloc(4092);
        push_alloc(1);
        push_alloc(100);
        push_alloc(INIT_SIZE);
        push_alloc(3000);
        push_alloc(600);
        push_free(HEADER_GRANULES + 1 + HEADER_GRANULES);
        push_free(7);
        push_free(HEADER_GRANULES);
        push_alloc(1);
        push_alloc(2);
        push_free(2 * HEADER_GRANULES + 1);
        push_alloc(2);
        push_alloc(4088);
        drain();

        // Long hold on responses while requests keep coming.
        for (int i = 0; i < 40; i++) push_alloc($urandom_range(1, 60));
        hold_go = 1;
        wait (hold_done);
        drain();

        // Random mix; known live addresses are collected from the model.
        for (int i = 0; i < 1550; i++)
        begin
            idle_off = (i >= 600 && i < 800);
            if (pending_reqs.size() > 8) @(posedge clk iff pending_reqs.size() <= 8);
            pick = $urandom_range(99);
            if (pick < 50)
            begin
                case ($urandom_range(9))
                    0: push_alloc($urandom_range(4095));
                    1: push_alloc($urandom_range(500, 1500));
                    default: push_alloc($urandom_range(1, 120));
                endcase
            end
            else if (pick < 88)
            begin
                live_blocks.delete();
                for (int c = 0; c < HEAP_GRANULES; c++)
                    if (hv[c] && !hf[c]) live_blocks.push_back(c + HEADER_GRANULES);
                if (live_blocks.size() > 0)
                    a = live_blocks[$urandom_range(live_blocks.size() - 1)];
                else
                    a = HEADER_GRANULES;
                push_free(a);
            end
            else if (pick < 95)
                push_free($urandom_range(4095));
            else
                push_alloc(0);
            // Let the model catch up so frees target current blocks.
            if (pick >= 50 && pick < 88) drain();
        end
        drain();
        repeat (200) @(posedge clk);
        if (errors == 0 && expected_rsps.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #100ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
